@@ rtl/lease_lock_with_reservation_assert.svh @@
// Assertion macros used by the lease lock top level.
`ifndef LEASE_LOCK_WITH_RESERVATION_ASSERT_SVH
`define LEASE_LOCK_WITH_RESERVATION_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define LLR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lease lock assertion failed");

// Next-cycle implication.
`define LLR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lease lock assertion failed");

`endif

@@ rtl/llr_pkg.sv @@
// Package: types and constants for the lease lock with reservation.
package llr_pkg;

	localparam int OWNER_BITS = 8;
	localparam int TIME_BITS  = 63;
	localparam int DL_BITS    = 64;
	localparam int HOLD_BITS  = 32;
	localparam int WIN_BITS   = 16;
	localparam int CNT_BITS   = 32;
	localparam int ADDR_BITS  = 3;
	localparam int DATA_BITS  = 32;

	localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(500);

	// register index taken from paddr[2]
	localparam logic REG_WINDOW = 1'b0;

	localparam logic [1:0] OP_TRY     = 2'd0;
	localparam logic [1:0] OP_FORCE   = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	typedef logic [OWNER_BITS-1:0] owner_t;
	typedef logic [DL_BITS-1:0]    deadline_t;
	typedef logic [CNT_BITS-1:0]   count_t;

	typedef struct packed {
		logic [1:0]           op;
		owner_t               owner;
		logic [TIME_BITS-1:0] now;
		logic [HOLD_BITS-1:0] hold;
	} req_t;

	typedef struct packed {
		logic   granted;
		owner_t holder;
		count_t acquires;
		count_t expiries;
		count_t steals;
	} res_t;

endpackage

@@ rtl/llr_core.sv @@
// Lock state, counters and the combinational next-state logic for one request.
module llr_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  llr_pkg::req_t                     req,
	input  logic [llr_pkg::WIN_BITS-1:0]      window,
	output llr_pkg::res_t                     res
);

	llr_pkg::owner_t    holder_q, waiter_q, holder_d, waiter_d;
	llr_pkg::deadline_t hold_dl_q, wait_dl_q, hold_dl_d, wait_dl_d;
	llr_pkg::count_t    acq_q, exp_q, stl_q, acq_d, exp_d, stl_d;

	llr_pkg::deadline_t now_ext, lease_end, resv_end;
	logic               who_nz, h_other, h_live, w_live, w_self, grant;

	assign now_ext   = llr_pkg::DL_BITS'(req.now);
	assign lease_end = now_ext + llr_pkg::DL_BITS'(req.hold);
	assign resv_end  = now_ext + llr_pkg::DL_BITS'(window);

	assign who_nz  = (req.owner != '0);
	assign h_other = (holder_q != '0) && (holder_q != req.owner);
	assign h_live  = (now_ext < hold_dl_q);
	assign w_live  = (waiter_q != '0) && (now_ext < wait_dl_q);
	assign w_self  = (waiter_q == req.owner);

	always_comb begin
		holder_d  = holder_q;
		waiter_d  = waiter_q;
		hold_dl_d = hold_dl_q;
		wait_dl_d = wait_dl_q;
		acq_d     = acq_q;
		exp_d     = exp_q;
		stl_d     = stl_q;
		grant     = 1'b0;
		if (who_nz) begin
			case (req.op)
				llr_pkg::OP_TRY: begin
					if (h_other && h_live) begin
						// busy: join or refresh the reservation
						if (w_self || !w_live) begin
							waiter_d  = req.owner;
							wait_dl_d = resv_end;
						end
					end else begin
						if (h_other) begin
							// stale lease reaped
							exp_d    = exp_q + 1'b1;
							holder_d = '0;
						end
						if (!(holder_d == '0 && w_live && !w_self)) begin
							if (w_self)
								waiter_d = '0;
							holder_d  = req.owner;
							hold_dl_d = lease_end;
							acq_d     = acq_q + 1'b1;
							grant     = 1'b1;
						end
					end
				end
				llr_pkg::OP_FORCE: begin
					if (w_self)
						waiter_d = '0;
					holder_d  = req.owner;
					hold_dl_d = lease_end;
					stl_d     = stl_q + 1'b1;
				end
				llr_pkg::OP_RELEASE: begin
					if (holder_q == req.owner)
						holder_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holder_q  <= '0;
			waiter_q  <= '0;
			hold_dl_q <= '0;
			wait_dl_q <= '0;
			acq_q     <= '0;
			exp_q     <= '0;
			stl_q     <= '0;
		end else if (step) begin
			holder_q  <= holder_d;
			waiter_q  <= waiter_d;
			hold_dl_q <= hold_dl_d;
			wait_dl_q <= wait_dl_d;
			acq_q     <= acq_d;
			exp_q     <= exp_d;
			stl_q     <= stl_d;
		end
	end

	assign res.granted  = grant;
	assign res.holder   = holder_d;
	assign res.acquires = acq_d;
	assign res.expiries = exp_d;
	assign res.steals   = stl_d;

endmodule

@@ rtl/lease_lock_with_reservation.sv @@
// Top level: lease lock with one-deep reservation, request/result channels and APB.
//
//  channel   dir  handshake           payload
//  request   in   in_valid/in_stall   operation, owner_id, now_ms, hold_ms
//  result    out  out_valid/out_stall granted, holder_now, *_total counters
//  config    in   APB psel/penable    reserve window (index 0, byte addr 0)
//
// A request is taken into the input register, decided and written to the result
// register when that is free or draining; one request per cycle without a stall.
// The rate is set by the single-pass decision logic (two 64-bit deadline compares
// and the deadline adders) between the input register and the result register.
// Reset clears the lock, reservation, counters and sets the window to 500 ms.
// A stalled result holds; one further request waits in the input register.
`include "lease_lock_with_reservation_assert.svh"

module lease_lock_with_reservation (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// request channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            operation,
	input  logic [7:0]                            owner_id,
	input  logic [llr_pkg::TIME_BITS-1:0]         now_ms,
	input  logic [llr_pkg::HOLD_BITS-1:0]         hold_ms,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  granted,
	output logic [7:0]                            holder_now,
	output logic [llr_pkg::CNT_BITS-1:0]          acquire_total,
	output logic [llr_pkg::CNT_BITS-1:0]          expiry_total,
	output logic [llr_pkg::CNT_BITS-1:0]          steal_total,
	// APB configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [llr_pkg::ADDR_BITS-1:0]         paddr,
	input  logic [llr_pkg::DATA_BITS-1:0]         pwdata,
	output logic [llr_pkg::DATA_BITS-1:0]         prdata,
	output logic                                  pready
);

	// ---- configuration register ----
	logic [llr_pkg::WIN_BITS-1:0] window_q;
	logic                         reg_idx;

	assign reg_idx = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= llr_pkg::WINDOW_RESET;
		end else if (psel && penable && pwrite && reg_idx == llr_pkg::REG_WINDOW) begin
			window_q <= pwdata[llr_pkg::WIN_BITS-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			llr_pkg::REG_WINDOW: prdata = llr_pkg::DATA_BITS'(window_q);
			default:             prdata = '0;
		endcase
	end

	// ---- input register ----
	llr_pkg::req_t req_s1;
	logic          vld_s1;
	logic          adv_s1;
	logic          in_take;

	// the decided request moves on when the result register is free or being drained
	logic          out_vld_q;
	assign adv_s1   = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_take) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1.op    <= operation;
			req_s1.owner <= llr_pkg::owner_t'(owner_id);
			req_s1.now   <= now_ms;
			req_s1.hold  <= hold_ms;
		end
	end

	// ---- lock state and decision ----
	llr_pkg::res_t res;

	llr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.req    (req_s1),
		.window (window_q),
		.res    (res)
	);

	// ---- result register ----
	llr_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_q <= res;
	end

	assign out_valid     = out_vld_q;
	assign granted       = res_q.granted;
	assign holder_now    = 8'(res_q.holder);
	assign acquire_total = res_q.acquires;
	assign expiry_total  = res_q.expiries;
	assign steal_total   = res_q.steals;

	// ---- assertions ----
	// back-pressure only ever comes from an occupied input register
	`LLR_ASSERT_IMP(a_stall_needs_item, in_stall, vld_s1)
	// a granted try always leaves the requester as holder
	`LLR_ASSERT_IMP(a_grant_holder, adv_s1 && res.granted, res.holder == req_s1.owner)
	// only a try can be granted
	`LLR_ASSERT_IMP(a_grant_is_try, adv_s1 && res.granted, req_s1.op == llr_pkg::OP_TRY)
	// a decided request always shows up as a result next cycle
	`LLR_ASSERT_NXT(a_result_follows, adv_s1, out_vld_q)

endmodule

@@ test/tb_top.sv @@
// Testbench for the lease lock with reservation: directed and random requests vs a predictor.
`timescale 1ns / 100ps

import llr_pkg::*;

class lease_scoreboard;
	owner_t holder;
	owner_t waiter;
	deadline_t holder_dl;
	deadline_t waiter_dl;
	count_t acquires;
	count_t expiries;
	count_t steals;
	logic [WIN_BITS-1:0] window;
	res_t outstanding[$];
	int failures;

	function new();
		holder = '0;
		waiter = '0;
		holder_dl = '0;
		waiter_dl = '0;
		acquires = '0;
		expiries = '0;
		steals = '0;
		window = WINDOW_RESET;
		failures = 0;
	endfunction

	function logic resv_active(deadline_t t);
		return waiter != '0 && t < waiter_dl;
	endfunction

	function void report(string what, logic [63:0] want, logic [63:0] got);
		failures++;
		if (failures <= 10)
			$display("mismatch on %s: expected %0h, got %0h", what, want, got);
	endfunction

	// Predict the outcome of one accepted request and queue it.
	function void note_request(req_t r);
		res_t want;
		deadline_t t;
		logic won;
		logic blocked;
		t = {1'b0, r.now};
		won = 1'b0;
		blocked = 1'b0;
		if (r.owner != '0) begin
			case (r.op)
				OP_TRY: begin
					if (holder != '0 && holder != r.owner) begin
						if (t < holder_dl) begin
							// lease still live: queue up or refresh own reservation
							if (waiter == r.owner || !resv_active(t)) begin
								waiter = r.owner;
								waiter_dl = t + window;
							end
							blocked = 1'b1;
						end else begin
							// stale lease is reaped even if the try then fails
							expiries = expiries + 1'b1;
							holder = '0;
						end
					end
					if (!blocked && holder == '0 && resv_active(t) && waiter != r.owner)
						blocked = 1'b1;
					if (!blocked) begin
						if (waiter == r.owner)
							waiter = '0;
						holder = r.owner;
						holder_dl = t + r.hold;
						acquires = acquires + 1'b1;
						won = 1'b1;
					end
				end
				OP_FORCE: begin
					if (waiter == r.owner)
						waiter = '0;
					holder = r.owner;
					holder_dl = t + r.hold;
					steals = steals + 1'b1;
				end
				OP_RELEASE: begin
					if (holder == r.owner)
						holder = '0;
				end
				default: ;
			endcase
		end
		want.granted = won;
		want.holder = holder;
		want.acquires = acquires;
		want.expiries = expiries;
		want.steals = steals;
		outstanding.push_back(want);
	endfunction

	function void check_result(res_t got);
		res_t want;
		if (outstanding.size() == 0) begin
			report("unrequested result, holder", '0, got.holder);
		end else begin
			want = outstanding.pop_front();
			if (got.granted !== want.granted)
				report("granted", want.granted, got.granted);
			if (got.holder !== want.holder)
				report("holder_now", want.holder, got.holder);
			if (got.acquires !== want.acquires)
				report("acquire_total", want.acquires, got.acquires);
			if (got.expiries !== want.expiries)
				report("expiry_total", want.expiries, got.expiries);
			if (got.steals !== want.steals)
				report("steal_total", want.steals, got.steals);
		end
	endfunction
endclass

module tb_top;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [ADDR_BITS-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
	localparam logic [HOLD_BITS-1:0] HOLD_MAX = '1;
	localparam int CYCLE_LIMIT = 300000;
	localparam int N_PHASES = 6;
	localparam int PHASE_REQUESTS = 250;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] operation;
	logic [7:0] owner_id;
	logic [TIME_BITS-1:0] now_ms;
	logic [HOLD_BITS-1:0] hold_ms;
	logic out_valid;
	logic out_stall = 1'b0;
	logic granted;
	logic [7:0] holder_now;
	logic [CNT_BITS-1:0] acquire_total;
	logic [CNT_BITS-1:0] expiry_total;
	logic [CNT_BITS-1:0] steal_total;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic pready;

	lease_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int cycles = 0;
	logic [TIME_BITS-1:0] sim_now;
	res_t seen;

	lease_lock_with_reservation dut (.*);

	always #5 clk = ~clk;

	// Result side: decide the stall on the falling edge, take results on the rising edge.
	always @(negedge clk)
		out_stall = ($urandom_range(0, 99) < recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.granted = granted;
			seen.holder = holder_now;
			seen.acquires = acquire_total;
			seen.expiries = expiry_total;
			seen.steals = steal_total;
			sb.check_result(seen);
		end
	end

	// Watchdog: a hung handshake ends the run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[lease_lock_with_reservation] ERROR");
			$finish;
		end
	end

	// Offer one request, possibly after a random gap, and hold it until taken.
	// Called and returns on a falling edge with in_valid low.
	task automatic send_request(input logic [1:0] op, input owner_t who,
		input logic [TIME_BITS-1:0] at, input logic [HOLD_BITS-1:0] len);
		req_t r;
		r.op = op;
		r.owner = who;
		r.now = at;
		r.hold = len;
		while ($urandom_range(0, 99) < send_idle_pct)
			@(negedge clk);
		operation = op;
		owner_id = who;
		now_ms = at;
		hold_ms = len;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(r);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic apb_write(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.window = data[WIN_BITS-1:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Read the window back; upper data bits are expected to read as zero.
	task automatic window_readback();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = ADDR_WINDOW;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== {{(DATA_BITS - WIN_BITS){1'b0}}, sb.window})
			sb.report("window readback", {{(DATA_BITS - WIN_BITS){1'b0}}, sb.window}, prdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.outstanding.size() != 0)
			@(negedge clk);
	endtask

	// Jump the clock of the requesters: anywhere, close to the top, or close to zero.
	task automatic new_time_base();
		int pick;
		pick = $urandom_range(0, 2);
		if (pick == 0)
			sim_now = TIME_BITS'({$urandom, $urandom});
		else if (pick == 1)
			sim_now = TIME_MAX - $urandom_range(0, 3000);
		else
			sim_now = TIME_BITS'($urandom_range(0, 1000));
	endtask

	// Mostly contention among a few owners with short leases, so that
	// reservations, expiries and steals keep happening; the rest is noise.
	task automatic random_request();
		logic [63:0] later;
		logic [1:0] op;
		owner_t who;
		logic [HOLD_BITS-1:0] len;
		int pick;
		if ($urandom_range(0, 149) == 0)
			new_time_base();
		later = {1'b0, sim_now} + $urandom_range(0, 12);
		sim_now = later[63] ? TIME_MAX : later[TIME_BITS-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 4)
			who = '0;
		else if (pick < 10)
			who = owner_t'($urandom_range(0, 255));
		else
			who = owner_t'($urandom_range(1, 4));
		pick = $urandom_range(0, 99);
		if (pick < 58)
			op = OP_TRY;
		else if (pick < 70)
			op = OP_FORCE;
		else if (pick < 96)
			op = OP_RELEASE;
		else
			op = OP_UNUSED;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			len = $urandom_range(0, 20);
		else if (pick < 95)
			len = $urandom_range(0, 2000);
		else
			len = $urandom;
		send_request(op, who, sim_now, len);
	endtask

	initial begin
		int windows [N_PHASES];
		windows = '{1, 65535, 12, 40, 0, 5};
		windows[4] = $urandom_range(1, 65535);
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_TRY;
		owner_id = '0;
		now_ms = '0;
		hold_ms = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sim_now = '0;
		send_idle_pct = 34;
		recv_idle_pct = 86;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset value of the window must read back as 500
		window_readback();

		// Directed: default window of 500 ms.
		send_request(OP_TRY, 8'd0, 63'd0, 32'd10);        // owner zero: nothing moves
		send_request(OP_UNUSED, 8'd5, 63'd10, 32'd10);    // spare op code: nothing moves
		send_request(OP_TRY, 8'd1, 63'd100, 32'd50);      // free lock taken
		send_request(OP_TRY, 8'd1, 63'd110, 32'd50);      // holder renews, counted again
		send_request(OP_TRY, 8'd2, 63'd120, 32'd5);       // blocked, becomes the waiter
		send_request(OP_RELEASE, 8'd3, 63'd130, 32'd0);   // release by a stranger
		send_request(OP_RELEASE, 8'd1, 63'd140, 32'd0);   // holder lets go, reservation stays
		send_request(OP_TRY, 8'd3, 63'd150, 32'd5);       // free but reserved for owner 2
		send_request(OP_TRY, 8'd2, 63'd160, 32'd0);       // waiter collects its turn, zero hold
		send_request(OP_TRY, 8'd3, 63'd161, 32'd10);      // stale lease reaped, then taken
		send_request(OP_TRY, 8'd4, 63'd165, 32'd5);       // owner 4 queues up
		send_request(OP_TRY, 8'd5, 63'd180, 32'd5);       // reaped, but blocked by owner 4
		send_request(OP_FORCE, 8'd6, 63'd190, HOLD_MAX);  // steal with longest hold
		send_request(OP_FORCE, 8'd4, 63'd200, 32'd1);     // waiter steals, loses its reservation
		send_request(OP_RELEASE, 8'd4, 63'd201, 32'd0);

		// Directed: zero window, reservations die at once.
		wait_drained();
		apb_write(ADDR_WINDOW, {16'hA5C3, 16'h0000});
		window_readback();
		send_request(OP_TRY, 8'd7, 63'd300, 32'd100);
		send_request(OP_TRY, 8'd8, 63'd310, 32'd5);       // waiter, but already dead
		send_request(OP_TRY, 8'd9, 63'd311, 32'd5);       // dead reservation is overwritten
		send_request(OP_RELEASE, 8'd7, 63'd320, 32'd0);
		send_request(OP_TRY, 8'd10, 63'd320, 32'd5);      // dead reservation does not block
		// time and hold at their upper ends, widest owner id
		send_request(OP_FORCE, 8'd255, TIME_MAX, HOLD_MAX);
		send_request(OP_TRY, 8'd1, TIME_MAX, 32'd0);
		send_request(OP_RELEASE, 8'd255, TIME_MAX, 32'd0);
		send_request(OP_UNUSED, 8'd255, TIME_MAX, HOLD_MAX);

		// Random phases: sender-light/receiver-heavy, then reversed, then free-running.
		for (int p = 0; p < N_PHASES; p++) begin
			wait_drained();
			if (p < 2) begin
				send_idle_pct = 34;
				recv_idle_pct = 86;
			end else if (p < 4) begin
				send_idle_pct = 86;
				recv_idle_pct = 34;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			apb_write(ADDR_WINDOW, {16'($urandom), 16'(windows[p])});
			window_readback();
			new_time_base();
			repeat (PHASE_REQUESTS) random_request();
		end

		// Drain, then let the pipeline idle to show any stray result.
		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.outstanding.size() == 0)
			$display("[lease_lock_with_reservation] OK");
		else
			$display("[lease_lock_with_reservation] ERROR");
		$finish;
	end
endmodule
